[rtl/xcfd_pkg.sv]
// Shared types and constants for the header/length/XOR frame deframer.
`default_nettype none

package xcfd_pkg;

  // Header byte sequence hunted for at the start of every frame
  localparam logic [7:0] HdrByte0 = 8'h55;
  localparam logic [7:0] HdrByte1 = 8'h4E;
  localparam logic [7:0] HdrByte2 = 8'h45;
  localparam logic [7:0] HdrByte3 = 8'h52;

  // Length counts command and separator; payload is length minus this
  localparam logic [7:0] LenOverhead = 8'd2;

  // Receive phase of the deframer
  typedef enum logic [2:0] {
    PhHunt = 3'd0,
    PhHdr1 = 3'd1,
    PhHdr2 = 3'd2,
    PhHdr3 = 3'd3,
    PhLen  = 3'd4,
    PhSep  = 3'd5,
    PhCmd  = 3'd6,
    PhBody = 3'd7
  } phase_e;

  // Kind of result passed downstream
  typedef enum logic [1:0] {
    KindCmd     = 2'd0,
    KindPayload = 2'd1,
    KindVerdict = 2'd2
  } kind_e;

  // One result request
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       frame_ok;
    logic       end_of_frame;
  } result_t;

endpackage

`default_nettype wire

[rtl/xor_checked_frame_deframer_core.sv]
// Top level of the header/length/XOR-checksum frame deframer.
//
//   channel | valid      | ready      | payload
//   --------+------------+------------+-------------------------------------------
//   rx      | rx_valid_i | rx_ready_o | rx_byte_i
//   out     | out_valid_o| out_ready_i| kind_o, data_o, frame_ok_o, end_of_frame_o
//
// One byte is accepted per cycle while rx_ready_o is high. The phase, length count
// and running XOR update in the same cycle the byte is accepted; any result lands
// in the output register, or in the skid register while that one is held.
// A one-entry skid register behind the output register keeps rx_ready_o
// independent of out_ready_i; rx_ready_o drops only while both hold a request.
// Reset (rst_ni low) returns to hunting the first header byte with no pending
// output.
`default_nettype none

module xor_checked_frame_deframer_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       rx_valid_i,
  output logic            rx_ready_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_o,
  output logic            frame_ok_o,
  output logic            end_of_frame_o
);

  xcfd_pkg::phase_e  phase_q, phase_d;
  logic [7:0]        remaining_q, remaining_d;
  logic [7:0]        xor_q, xor_d;

  logic              res_valid;
  xcfd_pkg::result_t res;

  logic              out_valid_q, skid_valid_q;
  xcfd_pkg::result_t out_q, skid_q;

  logic              rx_fire, out_fire, push;

  assign rx_ready_o = !skid_valid_q;
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;
  assign push       = rx_fire && res_valid;

  // Next state: header hunt, length capture and running XOR
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    xor_d       = xor_q;
    unique case (phase_q)
      xcfd_pkg::PhHunt, xcfd_pkg::PhHdr1, xcfd_pkg::PhHdr2, xcfd_pkg::PhHdr3: begin
        if (phase_q == xcfd_pkg::PhHdr1 && rx_byte_i == xcfd_pkg::HdrByte1) begin
          phase_d = xcfd_pkg::PhHdr2;
          xor_d   = xor_q ^ rx_byte_i;
        end else if (phase_q == xcfd_pkg::PhHdr2 && rx_byte_i == xcfd_pkg::HdrByte2) begin
          phase_d = xcfd_pkg::PhHdr3;
          xor_d   = xor_q ^ rx_byte_i;
        end else if (phase_q == xcfd_pkg::PhHdr3 && rx_byte_i == xcfd_pkg::HdrByte3) begin
          phase_d = xcfd_pkg::PhLen;
          xor_d   = xor_q ^ rx_byte_i;
        end else begin
          // Mismatch (or hunting): a first header byte restarts the header
          remaining_d = 8'd0;
          if (rx_byte_i == xcfd_pkg::HdrByte0) begin
            phase_d = xcfd_pkg::PhHdr1;
            xor_d   = xcfd_pkg::HdrByte0;
          end else begin
            phase_d = xcfd_pkg::PhHunt;
            xor_d   = 8'd0;
          end
        end
      end
      xcfd_pkg::PhLen: begin
        if (rx_byte_i < xcfd_pkg::LenOverhead) begin
          // Malformed length: drop the frame silently
          phase_d     = xcfd_pkg::PhHunt;
          remaining_d = 8'd0;
          xor_d       = 8'd0;
        end else begin
          phase_d     = xcfd_pkg::PhSep;
          remaining_d = rx_byte_i - xcfd_pkg::LenOverhead;
          xor_d       = xor_q ^ rx_byte_i;
        end
      end
      xcfd_pkg::PhSep: begin
        phase_d = xcfd_pkg::PhCmd;
        xor_d   = xor_q ^ rx_byte_i;
      end
      xcfd_pkg::PhCmd: begin
        phase_d = xcfd_pkg::PhBody;
        xor_d   = xor_q ^ rx_byte_i;
      end
      xcfd_pkg::PhBody: begin
        if (remaining_q != 8'd0) begin
          remaining_d = remaining_q - 8'd1;
          xor_d       = xor_q ^ rx_byte_i;
        end else begin
          phase_d = xcfd_pkg::PhHunt;
          xor_d   = 8'd0;
        end
      end
      default: begin
        phase_d     = xcfd_pkg::PhHunt;
        remaining_d = 8'd0;
        xor_d       = 8'd0;
      end
    endcase
  end

  // Result for the byte being accepted
  always_comb begin
    res_valid        = 1'b0;
    res.kind         = xcfd_pkg::KindCmd;
    res.data         = rx_byte_i;
    res.frame_ok     = 1'b0;
    res.end_of_frame = 1'b0;
    if (phase_q == xcfd_pkg::PhCmd) begin
      res_valid = 1'b1;
    end else if (phase_q == xcfd_pkg::PhBody) begin
      res_valid = 1'b1;
      if (remaining_q != 8'd0) begin
        res.kind = xcfd_pkg::KindPayload;
      end else begin
        res.kind         = xcfd_pkg::KindVerdict;
        res.frame_ok     = (xor_q == rx_byte_i);
        res.end_of_frame = 1'b1;
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= xcfd_pkg::PhHunt;
      remaining_q <= 8'd0;
      xor_q       <= 8'd0;
    end else if (rx_fire) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      xor_q       <= xor_d;
    end
  end

  // Output register plus skid entry, flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (!out_valid_q) begin
      out_valid_q <= push;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register plus skid entry, payload
  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (!out_valid_q) begin
      if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign data_o         = out_q.data;
  assign frame_ok_o     = out_q.frame_ok;
  assign end_of_frame_o = out_q.end_of_frame;

  // The skid entry only fills behind a held output request
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register empty");

  // Hunting always starts with a clean checksum and length count
  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == xcfd_pkg::PhHunt) |-> (xor_q == 8'd0 && remaining_q == 8'd0))
    else $error("hunt phase with stale checksum or length");

  // A checksum byte closes the frame and returns to hunting
  a_verdict_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && phase_q == xcfd_pkg::PhBody && remaining_q == 8'd0)
      |=> (phase_q == xcfd_pkg::PhHunt && out_valid_q))
    else $error("verdict did not close the frame");

  // Input is held off only while the output side is stalled
  a_ready_low_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> out_valid_o)
    else $error("input stalled without pending output");

endmodule

`default_nettype wire

[sim/xor_checked_frame_deframer_core_test.sv]
// Self-checking testbench for the XOR-checked frame deframer core.
`timescale 1ns / 1ps

module xor_checked_frame_deframer_core_test;

  // Receiver hold-off: starts at a fixed cycle, long enough to back up the input
  localparam int HoldStart = 300;
  localparam int HoldLen   = 400;
  localparam int RandItems = 1150;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       rx_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       rx_ready;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] data;
  logic       frame_ok;
  logic       end_of_frame;

  // Bytes waiting to be sent and results the deframer should produce
  logic [7:0]        rx_bytes_q [$];
  xcfd_pkg::result_t frame_results_q [$];

  // Deframer state as predicted
  xcfd_pkg::phase_e ph = xcfd_pkg::PhHunt;
  logic [7:0]       remain = 8'h00;
  logic [7:0]       xsum = 8'h00;

  int errors = 0;
  int tx_gap = 0, tx_calm = 0;
  int rd_gap = 0, rd_calm = 0;
  int rd_cycles = 0, hold_left = 0;

  xor_checked_frame_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .rx_valid_i     (rx_valid),
    .rx_ready_o     (rx_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .data_o         (data),
    .frame_ok_o     (frame_ok),
    .end_of_frame_o (end_of_frame)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hdr_byte(input int idx);
    case (idx)
      0: return xcfd_pkg::HdrByte0;
      1: return xcfd_pkg::HdrByte1;
      2: return xcfd_pkg::HdrByte2;
      default: return xcfd_pkg::HdrByte3;
    endcase
  endfunction

  // Header mismatch: a stray first header byte starts a new hunt at once
  task automatic rehunt(input logic [7:0] b);
    remain = 8'h00;
    if (b == xcfd_pkg::HdrByte0) begin
      xsum = xcfd_pkg::HdrByte0;
      ph = xcfd_pkg::PhHdr1;
    end else begin
      xsum = 8'h00;
      ph = xcfd_pkg::PhHunt;
    end
  endtask

  // Advance the predicted deframer by one byte, queue any result it gives
  task automatic deframe_byte(input logic [7:0] b);
    xcfd_pkg::result_t r;
    logic              got;
    r = '0;
    got = 1'b0;
    case (ph)
      xcfd_pkg::PhHunt: rehunt(b);
      xcfd_pkg::PhHdr1: begin
        if (b == xcfd_pkg::HdrByte1) begin
          xsum ^= b;
          ph = xcfd_pkg::PhHdr2;
        end else rehunt(b);
      end
      xcfd_pkg::PhHdr2: begin
        if (b == xcfd_pkg::HdrByte2) begin
          xsum ^= b;
          ph = xcfd_pkg::PhHdr3;
        end else rehunt(b);
      end
      xcfd_pkg::PhHdr3: begin
        if (b == xcfd_pkg::HdrByte3) begin
          xsum ^= b;
          ph = xcfd_pkg::PhLen;
        end else rehunt(b);
      end
      xcfd_pkg::PhLen: begin
        // too short to hold a command: drop the frame silently
        if (b < xcfd_pkg::LenOverhead) begin
          ph = xcfd_pkg::PhHunt;
          remain = 8'h00;
          xsum = 8'h00;
        end else begin
          remain = b - xcfd_pkg::LenOverhead;
          xsum ^= b;
          ph = xcfd_pkg::PhSep;
        end
      end
      xcfd_pkg::PhSep: begin
        xsum ^= b;
        ph = xcfd_pkg::PhCmd;
      end
      xcfd_pkg::PhCmd: begin
        xsum ^= b;
        ph = xcfd_pkg::PhBody;
        r.kind = xcfd_pkg::KindCmd;
        r.data = b;
        got = 1'b1;
      end
      default: begin
        got = 1'b1;
        r.data = b;
        if (remain != 8'h00) begin
          xsum ^= b;
          remain = remain - 8'd1;
          r.kind = xcfd_pkg::KindPayload;
        end else begin
          r.kind = xcfd_pkg::KindVerdict;
          r.frame_ok = (xsum == b);
          r.end_of_frame = 1'b1;
          ph = xcfd_pkg::PhHunt;
          xsum = 8'h00;
        end
      end
    endcase
    if (got) frame_results_q.push_back(r);
  endtask

  // Whole frame with random content; checksum corrupted when good is clear
  task automatic push_frame(input logic [7:0] len, input bit good);
    logic [7:0] x, b;
    int         i;
    x = len;
    for (i = 0; i < 4; i++) begin
      rx_bytes_q.push_back(hdr_byte(i));
      x ^= hdr_byte(i);
    end
    rx_bytes_q.push_back(len);
    // separator, command, then len-2 payload bytes
    for (i = 0; i < int'(len); i++) begin
      b = 8'($urandom_range(0, 255));
      rx_bytes_q.push_back(b);
      x ^= b;
    end
    if (!good) x ^= 8'($urandom_range(1, 255));
    rx_bytes_q.push_back(x);
  endtask

  // Sender: one request per handshake, random gaps between requests
  always @(posedge clk_i) begin
    if (!rst_n) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && rx_ready) deframe_byte(rx_byte);
      if (!rx_valid || rx_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          rx_valid <= 1'b0;
        end else if (rx_bytes_q.size() != 0) begin
          rx_valid <= 1'b1;
          rx_byte <= rx_bytes_q.pop_front();
          if (tx_calm != 0) begin
            tx_calm--;
          end else begin
            tx_gap = pick_idle();
            if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 80);
          end
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the block
  always @(posedge clk_i) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rd_cycles++;
      if (rd_cycles == HoldStart) hold_left = HoldLen;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rd_gap != 0) begin
        rd_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (rd_calm != 0) begin
          rd_calm--;
        end else begin
          rd_gap = pick_idle();
          if ($urandom_range(0, 49) == 0) rd_calm = $urandom_range(20, 80);
        end
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    xcfd_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_results_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d data %02h", $time, kind, data);
        errors++;
      end else begin
        want = frame_results_q.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
          errors++;
        end
        if (data !== want.data) begin
          $display("%0t: data expected %02h got %02h", $time, want.data, data);
          errors++;
        end
        if (frame_ok !== want.frame_ok) begin
          $display("%0t: frame_ok expected %0b got %0b", $time, want.frame_ok, frame_ok);
          errors++;
        end
        if (end_of_frame !== want.end_of_frame) begin
          $display("%0t: end_of_frame expected %0b got %0b", $time,
                   want.end_of_frame, end_of_frame);
          errors++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int counted, r, k;
    logic [7:0] len;

    // shortest frame: command straight followed by checksum
    push_frame(8'd2, 1'b1);
    // zero length and, after a doubled first header byte, length one
    for (k = 0; k < 4; k++) rx_bytes_q.push_back(hdr_byte(k));
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(xcfd_pkg::HdrByte0);
    for (k = 0; k < 4; k++) rx_bytes_q.push_back(hdr_byte(k));
    rx_bytes_q.push_back(8'h01);
    // broken header cut by an all-one byte, then an all-zero byte
    rx_bytes_q.push_back(xcfd_pkg::HdrByte0);
    rx_bytes_q.push_back(xcfd_pkg::HdrByte1);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(8'h00);
    // bad checksum, still consumed whole
    push_frame(8'd3, 1'b0);

    // longest frame once, then mostly short well-formed frames
    push_frame(8'd255, 1'b1);
    counted = rx_bytes_q.size();
    while (counted < RandItems) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        k = $urandom_range(0, 99);
        if (k < 85) len = 8'($urandom_range(2, 10));
        else if (k < 99) len = 8'($urandom_range(11, 40));
        else len = 8'($urandom_range(41, 120));
        push_frame(len, $urandom_range(0, 99) < 85);
        counted += int'(len) + 6;
      end else if (r < 90) begin
        // header cut short, then some byte that may restart it
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) rx_bytes_q.push_back(hdr_byte(i));
        rx_bytes_q.push_back(($urandom_range(0, 3) == 0) ? xcfd_pkg::HdrByte0
                                                         : 8'($urandom_range(0, 255)));
        counted += k + 1;
      end else if (r < 95) begin
        // malformed length with trailing junk
        for (k = 0; k < 4; k++) rx_bytes_q.push_back(hdr_byte(k));
        rx_bytes_q.push_back(8'($urandom_range(0, 1)));
        rx_bytes_q.push_back(8'($urandom_range(0, 255)));
        counted += 6;
      end else begin
        // line noise between frames
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
        counted += k;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;

    while (rx_bytes_q.size() != 0 || rx_valid) @(posedge clk_i);
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/xcfd_pkg.sv
rtl/xor_checked_frame_deframer_core.sv
sim/xor_checked_frame_deframer_core_test.sv
